@@ hdl/ifca_pkg.sv @@
// shared types, constants and coefficient tables for the iq fir combine agc block
// used by the mac, divider and core modules; no dependencies
`default_nettype none

package ifca_pkg;

  localparam int TAPS_DEF = 32;
  localparam int SMP_W    = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 2 * SMP_W;
  localparam int ACC_W    = 48;
  localparam int WORD_W   = 32;
  localparam int ROM_LEN  = 32;
  localparam int ROM_AW   = $clog2(ROM_LEN);
  localparam int TIDX_W   = 8;

  // configuration register indexes and reset values, at field width
  localparam logic [1:0] REG_SUM_SHIFT    = 2'd0;
  localparam logic [1:0] REG_ATTACK_SHIFT = 2'd1;
  localparam logic [1:0] REG_DECAY_SHIFT  = 2'd2;
  localparam logic [1:0] REG_ENV_SCALE    = 2'd3;

  localparam logic [3:0] SUM_SHIFT_RST    = 4'd5;
  localparam logic [3:0] ATTACK_SHIFT_RST = 4'd4;
  localparam logic [4:0] DECAY_SHIFT_RST  = 5'd10;
  localparam logic [4:0] ENV_SCALE_RST    = 5'd14;

  localparam logic [WORD_W-1:0] DIV_NUM = 32'hFFFF_FFFF;
  localparam logic [SMP_W-1:0]  SAT_POS = 16'h7FFF;
  localparam logic [SMP_W-1:0]  SAT_NEG = 16'h8000;
  localparam logic [WORD_W-1:0] SAT_POS_W = 32'h0000_7FFF;
  localparam logic [WORD_W-1:0] SAT_NEG_W = 32'h0000_8000;

  localparam logic signed [COEF_W-1:0] I_COEF [ROM_LEN] = '{
    -16'sd10727, -16'sd13071, -16'sd15002, -16'sd16162,
    -16'sd16243, -16'sd15032, -16'sd12436, -16'sd8509,
    -16'sd3455,   16'sd2391,   16'sd8585,   16'sd14624,
     16'sd19991,  16'sd24213,  16'sd26911,  16'sd27839,
     16'sd26911,  16'sd24213,  16'sd19991,  16'sd14624,
     16'sd8585,   16'sd2391,  -16'sd3455,  -16'sd8509,
    -16'sd12436, -16'sd15032, -16'sd16243, -16'sd16162,
    -16'sd15002, -16'sd13071, -16'sd10727,  16'sd0
  };

  localparam logic signed [COEF_W-1:0] Q_COEF [ROM_LEN] = '{
    -16'sd571,    16'sd964,    16'sd3493,   16'sd6884,
     16'sd10880,  16'sd15121,  16'sd19182,  16'sd22611,
     16'sd24984,  16'sd25951,  16'sd25282,  16'sd22893,
     16'sd18863,  16'sd13434,  16'sd6986,   16'sd0,
    -16'sd6986,  -16'sd13434, -16'sd18863, -16'sd22893,
    -16'sd25282, -16'sd25951, -16'sd24984, -16'sd22611,
    -16'sd19182, -16'sd15121, -16'sd10880, -16'sd6884,
    -16'sd3493,  -16'sd964,    16'sd571,    16'sd0
  };

  // taps past the end of the tables weigh zero
  function automatic logic signed [COEF_W-1:0] coef_i(input logic [TIDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (k < TIDX_W'(ROM_LEN)) c = I_COEF[k[ROM_AW-1:0]];
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_q(input logic [TIDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (k < TIDX_W'(ROM_LEN)) c = Q_COEF[k[ROM_AW-1:0]];
    return c;
  endfunction

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/ifca_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module ifca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/ifca_mac.sv @@
// delay lines for both channels and the shared multiply-accumulate pipeline
// depends on ifca_pkg and ifca_ram
`default_nettype none

module ifca_mac #(
  parameter int TAPS = ifca_pkg::TAPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ifca_pkg::mac_ctrl_t               ctrl,
  input  wire logic [$clog2(TAPS)-1:0]           wr_addr,
  input  wire logic signed [ifca_pkg::SMP_W-1:0] wr_i,
  input  wire logic signed [ifca_pkg::SMP_W-1:0] wr_q,
  input  wire logic [$clog2(TAPS)-1:0]           rd_addr,
  input  wire logic [$clog2(TAPS)-1:0]           tap,
  output logic signed [ifca_pkg::ACC_W-1:0]      acc,
  output logic                                   busy
);

  localparam int SW = ifca_pkg::SMP_W;
  localparam int PW = ifca_pkg::PROD_W;
  localparam int AccW = ifca_pkg::ACC_W;

  logic [TAPS-1:0]                     valid;
  logic [2*SW-1:0]                     rd_data;
  logic                                s1, s2, vld1;
  logic signed [ifca_pkg::COEF_W-1:0]  ci1, cq1;
  logic signed [SW-1:0]                si, sq;
  logic signed [PW-1:0]                p_i, p_q;

  ifca_ram #(.WIDTH(2 * SW), .DEPTH(TAPS)) u_line (
    .clk    (clk),
    .wr_en  (ctrl.wr_en),
    .wr_addr(wr_addr),
    .wr_data({wr_i, wr_q}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= ctrl.rd_en;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    vld1 <= valid[rd_addr];
    ci1  <= ifca_pkg::coef_i(ifca_pkg::TIDX_W'(tap));
    cq1  <= ifca_pkg::coef_q(ifca_pkg::TIDX_W'(tap));
  end

  assign si = vld1 ? $signed(rd_data[2*SW-1:SW]) : '0;
  assign sq = vld1 ? $signed(rd_data[SW-1:0])    : '0;

  always_ff @(posedge clk) begin
    p_i <= ci1 * si;
    p_q <= cq1 * sq;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (s2) begin
      acc <= acc + AccW'(p_i) + AccW'(p_q);
    end
  end

  assign busy = s1 | s2;

endmodule

`default_nettype wire

@@ hdl/ifca_div.sv @@
// restoring divider: all-ones word over a 33-bit divisor, one quotient bit a cycle
// depends on ifca_pkg
`default_nettype none

module ifca_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ifca_pkg::WORD_W:0]     divisor,
  output logic      [ifca_pkg::WORD_W-1:0]   quotient,
  output logic                               done
);

  localparam int WW = ifca_pkg::WORD_W;

  logic [WW:0]           rem;
  logic [WW:0]           den;
  logic [WW+1:0]         trial;
  logic [$clog2(WW)-1:0] cnt;
  logic                  busy;

  // dividend bits enter msb first
  assign trial = {rem, ifca_pkg::DIV_NUM[~cnt]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (trial >= {1'b0, den}) begin
        rem      <= (WW+1)'(trial - {1'b0, den});
        quotient <= {quotient[WW-2:0], 1'b1};
      end else begin
        rem      <= trial[WW:0];
        quotient <= {quotient[WW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/iq_fir_combine_agc_core.sv @@
// an accepted item passes through TAPS mac steps, pipeline drain, envelope update,
// a 32-step divider, gain multiply and saturation before out_valid rises
// the shared mac and the serial divider serve one item at a time, and in_ready
// stays low while an item is at work
// reset: synchronous; delay lines read as zero, envelope zero, registers at defaults
`default_nettype none

module iq_fir_combine_agc_core #(
  parameter int TAPS = ifca_pkg::TAPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [15:0] in_phase_sample,
  input  wire logic signed [15:0] quadrature_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_sample,
  output logic [31:0]      envelope_level,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(TAPS);
  localparam int WW = ifca_pkg::WORD_W;
  localparam int AccW = ifca_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ENV, S_DSTART, S_DIV, S_MUL, S_SAT
  } state_t;

  state_t state;

  logic [3:0] sum_shift;
  logic [3:0] attack_shift;
  logic [4:0] decay_shift;
  logic [4:0] envelope_scale_shift;

  logic [AW-1:0] wp, wp_next, rptr, tap;
  logic          accept, mac_busy, div_done;
  ifca_pkg::mac_ctrl_t mac_ctrl;
  logic signed [AccW-1:0] acc;
  logic [AccW-1:0] acc_sh;
  logic [WW-1:0]   v, mag_c, mag, env, env_next, gain;
  logic            neg;
  logic [2*WW-1:0] prod;
  logic [WW-1:0]   q;
  logic [15:0]     sat;
  logic [WW:0]     divisor;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_shift            <= ifca_pkg::SUM_SHIFT_RST;
      attack_shift         <= ifca_pkg::ATTACK_SHIFT_RST;
      decay_shift          <= ifca_pkg::DECAY_SHIFT_RST;
      envelope_scale_shift <= ifca_pkg::ENV_SCALE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        ifca_pkg::REG_SUM_SHIFT:    sum_shift            <= pwdata[3:0];
        ifca_pkg::REG_ATTACK_SHIFT: attack_shift         <= pwdata[3:0];
        ifca_pkg::REG_DECAY_SHIFT:  decay_shift          <= pwdata[4:0];
        ifca_pkg::REG_ENV_SCALE:    envelope_scale_shift <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ifca_pkg::REG_SUM_SHIFT:    prdata = {28'd0, sum_shift};
      ifca_pkg::REG_ATTACK_SHIFT: prdata = {28'd0, attack_shift};
      ifca_pkg::REG_DECAY_SHIFT:  prdata = {27'd0, decay_shift};
      ifca_pkg::REG_ENV_SCALE:    prdata = {27'd0, envelope_scale_shift};
      default:                    prdata = '0;
    endcase
  end

  // sequencer controls
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wp_next  = (wp == AW'(TAPS - 1)) ? '0 : wp + 1'b1;

  assign mac_ctrl.wr_en = accept;
  assign mac_ctrl.clr   = accept;
  assign mac_ctrl.rd_en = (state == S_MAC);

  ifca_mac #(.TAPS(TAPS)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .wr_addr(wp),
    .wr_i   (in_phase_sample),
    .wr_q   (quadrature_sample),
    .rd_addr(rptr),
    .tap    (tap),
    .acc    (acc),
    .busy   (mac_busy)
  );

  // rectify the wrapped sum and step the envelope
  assign acc_sh = $unsigned(acc) >> sum_shift;
  assign v      = acc_sh[WW-1:0];
  assign mag_c  = v[WW-1] ? (WW'(0) - v) : v;

  always_comb begin
    if (mag_c >= env) env_next = env + ((mag_c - env) >> attack_shift);
    else              env_next = env - ((env - mag_c) >> decay_shift);
  end

  assign divisor = {1'b0, env >> envelope_scale_shift} + {{WW{1'b0}}, 1'b1};

  ifca_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_DSTART),
    .divisor (divisor),
    .quotient(gain),
    .done    (div_done)
  );

  assign q = prod[2*WW-1:WW];

  always_comb begin
    if (!neg) sat = (q > ifca_pkg::SAT_POS_W) ? ifca_pkg::SAT_POS : q[15:0];
    else      sat = (q > ifca_pkg::SAT_NEG_W) ? ifca_pkg::SAT_NEG : 16'(16'd0 - q[15:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      env       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_SAT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            wp    <= wp_next;
            rptr  <= wp_next;
            tap   <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          rptr <= (rptr == AW'(TAPS - 1)) ? '0 : rptr + 1'b1;
          tap  <= tap + 1'b1;
          if (tap == AW'(TAPS - 1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!mac_busy) state <= S_ENV;
        end
        S_ENV: begin
          env   <= env_next;
          mag   <= mag_c;
          neg   <= v[WW-1];
          state <= S_DSTART;
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= (2*WW)'(mag) * (2*WW)'(gain);
          state <= S_SAT;
        end
        S_SAT: begin
          // hold here until the output register is free
          if (!out_valid || out_ready) begin
            out_sample     <= $signed(sat);
            envelope_level <= env;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/ifca_checker.sv @@
// port-level checks on the item handshakes of the core
// bound to iq_fir_combine_agc_core; no package use
`default_nettype none

module ifca_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_sample,
  input wire logic [31:0] envelope_level
);

  // leaving reset the core is idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk) rst |=> (in_ready && !out_valid))
    else $error("core not idle after reset");

  // an accepted item keeps the input closed; it must not reopen early
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready))
    else $error("input reopened too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_sample) && $stable(envelope_level)))
    else $error("stalled result changed");

endmodule

bind iq_fir_combine_agc_core ifca_checker u_ifca_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_sample    (out_sample),
  .envelope_level(envelope_level)
);

`default_nettype wire
